>>> rtl/core/jse_pkg.sv
// ----------------------------------------------------------------------------
// JSON string escaper package
// Payload structs, op and token codes, and the escape helpers shared by the
// front, the queue and the back of the escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

	// Input op codes
	localparam logic [1:0] OP_OPEN  = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	// ASCII bytes used by the escapes
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;

	// Token queue depth between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Longest escape is six bytes
	localparam int POS_W = 3;
	localparam logic [POS_W-1:0] POS_LAST_LIT  = 3'd0;
	localparam logic [POS_W-1:0] POS_LAST_PAIR = 3'd1;
	localparam logic [POS_W-1:0] POS_LAST_UNI  = 3'd5;
	localparam logic [POS_W-1:0] POS_BSLASH = 3'd0;
	localparam logic [POS_W-1:0] POS_U      = 3'd1;
	localparam logic [POS_W-1:0] POS_ZERO_A = 3'd2;
	localparam logic [POS_W-1:0] POS_ZERO_B = 3'd3;
	localparam logic [POS_W-1:0] POS_HEX_HI = 3'd4;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// Token kinds: literal byte, backslash pair, \u00XX escape
	typedef enum logic [1:0] {
		KIND_LIT  = 2'd0,
		KIND_PAIR = 2'd1,
		KIND_UNI  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} token_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = 8'h30 + {4'd0, nib};
		end else begin
			d = 8'h57 + {4'd0, nib};
		end
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/jse_front.sv
// ----------------------------------------------------------------------------
// JSON string escaper front
// Accepts input items and classifies each into one escape token; unused ops
// are accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_front import jse_pkg::*; (
	input  wire logic     valid,
	input  var  in_item_t data,
	output logic          stall,
	input  wire logic     q_full,
	output logic          push,
	output token_t        tok
);

	logic accept;

	assign stall  = q_full;
	assign accept = valid && !q_full;

	always_comb begin
		tok.kind  = KIND_LIT;
		tok.value = data.data_byte;
		push      = 1'b0;
		unique case (data.op) inside
			OP_OPEN, OP_CLOSE: begin
				push      = accept;
				tok.value = CH_QUOTE;
			end
			OP_DATA: begin
				push = accept;
				case (data.data_byte) inside
					CH_QUOTE, CH_BSLASH: tok.kind = KIND_PAIR;
					8'h08: begin tok.kind = KIND_PAIR; tok.value = 8'h62; end
					8'h0C: begin tok.kind = KIND_PAIR; tok.value = 8'h66; end
					8'h0A: begin tok.kind = KIND_PAIR; tok.value = 8'h6E; end
					8'h0D: begin tok.kind = KIND_PAIR; tok.value = 8'h72; end
					8'h09: begin tok.kind = KIND_PAIR; tok.value = 8'h74; end
					default: begin
						if (data.data_byte < CH_PRINT_LO ||
							data.data_byte > CH_PRINT_HI) begin
							tok.kind = KIND_UNI;
						end
					end
				endcase
			end
			default: push = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/jse_queue.sv
// ----------------------------------------------------------------------------
// JSON string escaper token queue
// Small FIFO that decouples classification from byte emission.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_queue import jse_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  var  token_t push_tok,
	output logic        full,
	input  wire logic   pop,
	output token_t      head,
	output logic        empty
);

	token_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= QPTR_W'((32'(wr_ptr_q) + 1) % QDEPTH);
			end
			if (do_pop) begin
				rd_ptr_q <= QPTR_W'((32'(rd_ptr_q) + 1) % QDEPTH);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/jse_back.sv
// ----------------------------------------------------------------------------
// JSON string escaper back
// Expands one token at a time into its escape bytes behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_back import jse_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_empty,
	input  var  token_t q_head,
	output logic        q_pop,
	output logic        valid,
	input  wire logic   stall,
	output out_item_t   data
);

	token_t           cur_q;
	logic             cur_valid_q;
	logic [POS_W-1:0] pos_q;
	out_item_t        out_q;
	logic             out_valid_q;
	logic             adv;
	logic             last;
	logic             fin;
	logic [7:0]       byte_c;

	assign valid = out_valid_q;
	assign data  = out_q;
	assign adv   = !out_valid_q || !stall;

	always_comb begin
		byte_c = cur_q.value;
		last   = 1'b0;
		unique case (cur_q.kind)
			KIND_LIT: begin
				last = (pos_q == POS_LAST_LIT);
			end
			KIND_PAIR: begin
				last = (pos_q == POS_LAST_PAIR);
				if (pos_q == POS_BSLASH) begin
					byte_c = CH_BSLASH;
				end
			end
			KIND_UNI: begin
				last = (pos_q == POS_LAST_UNI);
				case (pos_q) inside
					POS_BSLASH: byte_c = CH_BSLASH;
					POS_U:      byte_c = CH_U;
					POS_ZERO_A, POS_ZERO_B: byte_c = CH_ZERO;
					POS_HEX_HI: byte_c = hex_digit(cur_q.value[7:4]);
					default:    byte_c = hex_digit(cur_q.value[3:0]);
				endcase
			end
			default: last = 1'b1;
		endcase
	end

	assign fin   = cur_valid_q && adv && last;
	assign q_pop = !q_empty && (!cur_valid_q || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= cur_valid_q;
			end
			// load next token, retire a finished one, or step to the next byte
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				pos_q       <= '0;
			end else if (fin) begin
				cur_valid_q <= 1'b0;
			end else if (cur_valid_q && adv) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (adv && cur_valid_q) begin
			out_q.out_byte <= byte_c;
			out_q.run_last <= last;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/json_string_escaper.sv
// An item passes the token queue, token register and output register in turn.
// Throughput: one byte per cycle unless stalled; items give 1, 2 or 6 bytes.
// Input rate is one item per cycle while the four-entry token queue has room.
// Reset clears the queue, the token register and the output valid at once.
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns open/data/close items into the escaped bytes of a JSON string.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper import jse_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  var  in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);

	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	token_t tok;
	token_t head;

	jse_front u_front (
		.valid  (in_valid),
		.data   (in_data),
		.stall  (in_stall),
		.q_full (q_full),
		.push   (push),
		.tok    (tok)
	);

	jse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (tok),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	jse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (head),
		.q_pop   (pop),
		.valid   (out_valid),
		.stall   (out_stall),
		.data    (out_data)
	);

endmodule

`default_nettype wire

>>> rtl/core/jse_checker.sv
// ----------------------------------------------------------------------------
// JSON string escaper checker
// Port-level properties of the escaped output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_checker import jse_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input var  out_item_t out_data
);

	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_HEX_A = 8'h61;
	localparam logic [7:0] CH_HEX_F = 8'h66;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output changed");

	// escaped text is always printable ASCII
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.out_byte >= CH_PRINT_LO &&
			out_data.out_byte <= CH_PRINT_HI))
		else $error("non-printable output byte");

	// only escape prefixes and hex digits appear before the last byte of a run
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.run_last |-> (out_data.out_byte == CH_BSLASH ||
			out_data.out_byte == CH_U ||
			(out_data.out_byte >= CH_ZERO && out_data.out_byte <= CH_NINE) ||
			(out_data.out_byte >= CH_HEX_A && out_data.out_byte <= CH_HEX_F)))
		else $error("unexpected byte inside an escape");

	// a u inside an escape comes after a valid byte that is not the last of its run
	a_no_lone_u: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.run_last && out_data.out_byte == CH_U
		|-> $past(out_valid) && !$past(out_data.run_last))
		else $error("escape letter u without preceding backslash");

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);

`default_nettype wire

>>> sim/json_string_escaper_checker.sv
// ----------------------------------------------------------------------------
// JSON string escaper checker
// Watches both channels of the escaper. Each input transfer is escaped here
// into the bytes it should cause. Each output transfer is compared with the
// oldest of them.
// ----------------------------------------------------------------------------

module json_string_escaper_checker import jse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending,
	output int        bytes_checked
);

	localparam logic [7:0] ESC_B = "b";
	localparam logic [7:0] ESC_F = "f";
	localparam logic [7:0] ESC_N = "n";
	localparam logic [7:0] ESC_R = "r";
	localparam logic [7:0] ESC_T = "t";

	out_item_t escaped_bytes[$];

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib > 4'd9) ? 8'("a") + 8'(nib - 4'd10) : 8'("0") + 8'(nib);
	endfunction

	// Queue the escaped text of one input transfer
	function automatic void escape_item(input in_item_t it);
		logic [7:0] seq [6];
		logic [7:0] letter;
		int n;
		out_item_t r;
		n = 0;
		letter = 8'h00;
		case (it.op) inside
			OP_OPEN, OP_CLOSE: begin
				seq[0] = CH_QUOTE;
				n = 1;
			end
			OP_DATA: begin
				case (it.data_byte)
					CH_QUOTE:  letter = CH_QUOTE;
					CH_BSLASH: letter = CH_BSLASH;
					8'h08:     letter = ESC_B;
					8'h0C:     letter = ESC_F;
					8'h0A:     letter = ESC_N;
					8'h0D:     letter = ESC_R;
					8'h09:     letter = ESC_T;
					default:   letter = 8'h00;
				endcase
				if (letter != 8'h00) begin
					seq[0] = CH_BSLASH;
					seq[1] = letter;
					n = 2;
				end else if (it.data_byte < CH_PRINT_LO || it.data_byte > CH_PRINT_HI) begin
					seq[0] = CH_BSLASH;
					seq[1] = CH_U;
					seq[2] = CH_ZERO;
					seq[3] = CH_ZERO;
					seq[4] = hex_char(it.data_byte[7:4]);
					seq[5] = hex_char(it.data_byte[3:0]);
					n = 6;
				end else begin
					seq[0] = it.data_byte;
					n = 1;
				end
			end
			default: n = 0;
		endcase
		for (int k = 0; k < n; k++) begin
			r.out_byte = seq[k];
			r.run_last = (k == n - 1);
			escaped_bytes = {escaped_bytes, r};
		end
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				bytes_checked++;
				if (escaped_bytes.size() == 0) begin
					$error("unexpected output transfer: out_byte 8'h%02h run_last %0b",
						out_data.out_byte, out_data.run_last);
					fail_count++;
				end else begin
					want = escaped_bytes.pop_front();
					if (out_data.out_byte !== want.out_byte) begin
						$error("out_byte: expected 8'h%02h, got 8'h%02h",
							want.out_byte, out_data.out_byte);
						fail_count++;
					end
					if (out_data.run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b",
							want.run_last, out_data.run_last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				escape_item(in_data);
			pending = escaped_bytes.size();
		end
	end

endmodule

>>> sim/tb_json_string_escaper.sv
// ----------------------------------------------------------------------------
// JSON string escaper testbench
// Feeds framed strings, stray items and unused ops into the escaper with
// random gaps and output stalls, including one long output hold-off, and lets
// the checker compare every escaped byte.
// ----------------------------------------------------------------------------

module tb_json_string_escaper import jse_pkg::*; ();

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;

	int fail_count;
	int pending;
	int bytes_checked;

	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit quiet = 1'b0;

	int n_frames;
	int n_data;
	int n_ignored;

	json_string_escaper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	json_string_escaper_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.bytes_checked (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("json_string_escaper: mismatch");
		$finish;
	end

	// Output side: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic in_item_t mk(input logic [1:0] op, input logic [7:0] b);
		in_item_t it;
		it.op = op;
		it.data_byte = b;
		return it;
	endfunction

	// Mix printable text, named escapes and arbitrary bytes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9)) inside
			[0:3]: return 8'($urandom_range(8'h20, 8'h7E));
			4: begin
				case ($urandom_range(0, 6))
					0: return CH_QUOTE;
					1: return CH_BSLASH;
					2: return 8'h08;
					3: return 8'h0C;
					4: return 8'h0A;
					5: return 8'h0D;
					default: return 8'h09;
				endcase
			end
			default: return 8'($urandom);
		endcase
	endfunction

	// Hold the item until the transfer, then maybe leave a gap
	task automatic send_item(input in_item_t it, input bit gaps);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		case (it.op) inside
			OP_OPEN, OP_CLOSE: n_frames++;
			OP_DATA:           n_data++;
			default:           n_ignored++;
		endcase
		if (gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_strings(input int target, input bit gaps);
		int sent;
		int len;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 4) != 0) begin
				len = $urandom_range(0, 8);
				send_item(mk(OP_OPEN, 8'($urandom)), gaps);
				for (int k = 0; k < len; k++)
					send_item(mk(OP_DATA, pick_byte()), gaps);
				send_item(mk(OP_CLOSE, 8'($urandom)), gaps);
				sent += len + 2;
			end else begin
				case ($urandom_range(0, 2))
					0: send_item(mk(OP_UNUSED, 8'($urandom)), gaps);
					1: begin
						send_item(mk(OP_DATA, 8'($urandom)), gaps);
						sent++;
					end
					default: begin
						send_item(mk($urandom_range(0, 1) ? OP_OPEN : OP_CLOSE,
							8'($urandom)), gaps);
						sent++;
					end
				endcase
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: frame marks, every escape class and the range edges
		send_item(mk(OP_OPEN, 8'hFF), 1'b1);
		send_item(mk(OP_DATA, 8'h00), 1'b1);
		send_item(mk(OP_DATA, 8'hFF), 1'b1);
		send_item(mk(OP_DATA, CH_QUOTE), 1'b1);
		send_item(mk(OP_DATA, CH_BSLASH), 1'b1);
		send_item(mk(OP_DATA, 8'h08), 1'b1);
		send_item(mk(OP_DATA, 8'h0C), 1'b1);
		send_item(mk(OP_DATA, 8'h0A), 1'b1);
		send_item(mk(OP_DATA, 8'h0D), 1'b1);
		send_item(mk(OP_DATA, 8'h09), 1'b1);
		send_item(mk(OP_DATA, 8'h1F), 1'b1);
		send_item(mk(OP_DATA, 8'h20), 1'b1);
		send_item(mk(OP_DATA, 8'h7E), 1'b1);
		send_item(mk(OP_DATA, 8'h7F), 1'b1);
		send_item(mk(OP_DATA, 8'h80), 1'b1);
		send_item(mk(OP_DATA, 8'hA5), 1'b1);
		send_item(mk(OP_DATA, 8'h41), 1'b1);
		send_item(mk(OP_UNUSED, 8'h22), 1'b1);
		send_item(mk(OP_CLOSE, 8'hA5), 1'b1);
		send_item(mk(OP_UNUSED, 8'h00), 1'b1);
		send_item(mk(OP_CLOSE, 8'h5A), 1'b1);
		drain();

		send_strings(50, 1'b1);

		// Fill the token queue behind a long output hold-off
		hold_req = 1'b1;
		send_item(mk(OP_OPEN, 8'h00), 1'b0);
		for (int k = 0; k < 14; k++)
			send_item(mk(OP_DATA, k[0] ? 8'($urandom_range(8'h80, 8'hFF))
				: 8'($urandom_range(8'h00, 8'h1F))), 1'b0);
		send_item(mk(OP_CLOSE, 8'h00), 1'b0);
		in_valid <= 1'b0;
		while (!hold_done) @(posedge clk);
		drain();
		repeat ($urandom_range(1, 12)) @(posedge clk);

		send_strings(40, 1'b1);

		// Last stretch at full rate on both sides
		quiet = 1'b1;
		send_strings(24, 1'b0);
		in_valid <= 1'b0;

		for (int w = 0; w < 5000 && pending != 0; w++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending != 0)
			$error("%0d escaped bytes never arrived", pending);

		$display("Sent %0d frame marks, %0d data bytes and %0d unused ops;",
			n_frames, n_data, n_ignored);
		$display("checked %0d escaped bytes, with a long output hold-off.", bytes_checked);
		if (fail_count == 0 && pending == 0)
			$display("json_string_escaper: match");
		else
			$display("json_string_escaper: mismatch");
		$finish;
	end

endmodule
